// ----- rtl/core/flcm_pkg.sv -----
// ----------------------------------------------------------------------------
// flcm_pkg
// Shared widths, codes and control types for the fraction LCM accumulator.
// ----------------------------------------------------------------------------
package flcm_pkg;

    localparam int FIELD_W     = 64;
    localparam int VALUE_WIDTH = 64;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int ADD_W       = VALUE_WIDTH + 2;

    typedef logic [FIELD_W-1:0]     field_t;
    typedef logic [VALUE_WIDTH-1:0] val_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [ADD_W-1:0]       add_t;

    localparam cnt_t CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_HOLD,
        OP_LOAD_GCD_NUM,
        OP_LOAD_GCD_DEN,
        OP_GCD_STEP,
        OP_GCD_FIN,
        OP_LOAD_DIV,
        OP_DIV_STEP,
        OP_LOAD_MUL,
        OP_MUL_STEP
    } alu_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_GCD1,
        S_G1FIN,
        S_DIVLD,
        S_DIV,
        S_MULLD,
        S_MUL,
        S_CHK,
        S_GCD2,
        S_G2FIN,
        S_COMMIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        alu_op_t op;
        logic    idle;
        logic    clr_err;
        logic    set_zero;
        logic    set_ovf;
        logic    load_acc;
        logic    save_prod;
        logic    commit;
        logic    emit;
    } seq_ctrl_t;

    typedef struct packed {
        logic gcd_done;
        logic cnt_last;
        logic ov;
    } alu_stat_t;

endpackage

// ----- rtl/core/flcm_if.sv -----
// ----------------------------------------------------------------------------
// flcm_if
// Valid/ready channels for fraction requests and accumulator results.
// ----------------------------------------------------------------------------
interface flcm_item_if;
    import flcm_pkg::*;

    logic   valid;
    logic   ready;
    logic   start_req;
    field_t rate_num;
    field_t rate_den;

    modport source (output valid, start_req, rate_num, rate_den, input ready);
    modport sink   (input valid, start_req, rate_num, rate_den, output ready);
endinterface

interface flcm_result_if;
    import flcm_pkg::*;

    logic       valid;
    logic       ready;
    field_t     base_num;
    field_t     base_den;
    logic [1:0] status;

    modport source (output valid, base_num, base_den, status, input ready);
    modport sink   (input valid, base_num, base_den, status, output ready);
endinterface

// ----- rtl/core/flcm_alu.sv -----
// ----------------------------------------------------------------------------
// flcm_alu
// Shared add/subtract unit with working registers for binary GCD,
// restoring division and shift-add multiplication with overflow detect.
// ----------------------------------------------------------------------------
module flcm_alu (
    input  logic              clk,
    input  flcm_pkg::alu_op_t op,
    input  flcm_pkg::val_t    acc_num,
    input  flcm_pkg::val_t    acc_den,
    input  flcm_pkg::val_t    rate_num,
    input  flcm_pkg::val_t    rate_den,
    output flcm_pkg::val_t    x_out,
    output flcm_pkg::val_t    y_out,
    output flcm_pkg::alu_stat_t stat
);
    import flcm_pkg::*;

    val_t x_reg, x_next;
    val_t y_reg, y_next;
    val_t z_reg, z_next;
    cnt_t k_reg, k_next;
    cnt_t cnt_reg, cnt_next;
    logic ov_reg, ov_next;

    add_t opa, opb, sum;
    logic sub;

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        k_reg   <= k_next;
        cnt_reg <= cnt_next;
        ov_reg  <= ov_next;
    end

    assign sum = opa + (opb ^ {ADD_W{sub}}) + ADD_W'(sub);

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        k_next   = k_reg;
        cnt_next = cnt_reg;
        ov_next  = ov_reg;
        opa      = {2'b00, x_reg};
        opb      = {2'b00, y_reg};
        sub      = 1'b1;
        case (op)
            OP_HOLD:
            begin
            end
            OP_LOAD_GCD_NUM:
            begin
                x_next = acc_num;
                y_next = rate_num;
                k_next = '0;
            end
            OP_LOAD_GCD_DEN:
            begin
                x_next = acc_den;
                y_next = rate_den;
                k_next = '0;
            end
            OP_GCD_STEP:
            begin
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + CNT_W'(1);
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (sum[ADD_W-1])
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
                else
                begin
                    x_next = sum[VALUE_WIDTH:1];
                end
            end
            OP_GCD_FIN:
            begin
                y_next = ((x_reg == '0) ? y_reg : x_reg) << k_reg;
            end
            OP_LOAD_DIV:
            begin
                x_next   = '0;
                z_next   = acc_num;
                cnt_next = CNT_LAST;
            end
            OP_DIV_STEP:
            begin
                opa      = {1'b0, x_reg, z_reg[VALUE_WIDTH-1]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (!sum[ADD_W-1])
                begin
                    x_next = sum[VALUE_WIDTH-1:0];
                    z_next = {z_reg[VALUE_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    x_next = opa[VALUE_WIDTH-1:0];
                    z_next = {z_reg[VALUE_WIDTH-2:0], 1'b0};
                end
            end
            OP_LOAD_MUL:
            begin
                x_next   = '0;
                y_next   = rate_num;
                ov_next  = 1'b0;
                cnt_next = CNT_LAST;
            end
            OP_MUL_STEP:
            begin
                opa      = {1'b0, x_reg, 1'b0};
                opb      = z_reg[VALUE_WIDTH-1] ? {2'b00, y_reg} : '0;
                sub      = 1'b0;
                x_next   = sum[VALUE_WIDTH-1:0];
                ov_next  = ov_reg | sum[ADD_W-1] | sum[ADD_W-2];
                z_next   = {z_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign x_out         = x_reg;
    assign y_out         = y_reg;
    assign stat.gcd_done = (x_reg == '0) || (y_reg == '0);
    assign stat.cnt_last = (cnt_reg == '0);
    assign stat.ov       = ov_reg;

endmodule

// ----- rtl/core/flcm_seq.sv -----
// ----------------------------------------------------------------------------
// flcm_seq
// Sequencer stepping one request through GCD, divide, multiply and GCD.
// ----------------------------------------------------------------------------
module flcm_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  start_req,
    input  logic                  zero_rate,
    input  logic                  err_set,
    input  flcm_pkg::alu_stat_t   stat,
    output flcm_pkg::seq_ctrl_t   ctrl
);
    import flcm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        ctrl.op    = OP_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                ctrl.idle = 1'b1;
                if (accept)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (start_req)
                begin
                    ctrl.clr_err  = 1'b1;
                    ctrl.set_zero = zero_rate;
                    ctrl.load_acc = !zero_rate;
                    state_next    = S_EMIT;
                end
                else if (err_set)
                begin
                    state_next = S_EMIT;
                end
                else if (zero_rate)
                begin
                    ctrl.set_zero = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    ctrl.op    = OP_LOAD_GCD_NUM;
                    state_next = S_GCD1;
                end
            end
            S_GCD1:
            begin
                if (stat.gcd_done)
                begin
                    state_next = S_G1FIN;
                end
                else
                begin
                    ctrl.op = OP_GCD_STEP;
                end
            end
            S_G1FIN:
            begin
                ctrl.op    = OP_GCD_FIN;
                state_next = S_DIVLD;
            end
            S_DIVLD:
            begin
                ctrl.op    = OP_LOAD_DIV;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                ctrl.op = OP_DIV_STEP;
                if (stat.cnt_last)
                begin
                    state_next = S_MULLD;
                end
            end
            S_MULLD:
            begin
                ctrl.op    = OP_LOAD_MUL;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                ctrl.op = OP_MUL_STEP;
                if (stat.cnt_last)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (stat.ov)
                begin
                    ctrl.set_ovf = 1'b1;
                    state_next   = S_EMIT;
                end
                else
                begin
                    ctrl.save_prod = 1'b1;
                    ctrl.op        = OP_LOAD_GCD_DEN;
                    state_next     = S_GCD2;
                end
            end
            S_GCD2:
            begin
                if (stat.gcd_done)
                begin
                    state_next = S_G2FIN;
                end
                else
                begin
                    ctrl.op = OP_GCD_STEP;
                end
            end
            S_G2FIN:
            begin
                ctrl.op    = OP_GCD_FIN;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                ctrl.commit = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                ctrl.emit  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/fraction_lcm_accumulator.sv -----
// ----------------------------------------------------------------------------
// fraction_lcm_accumulator
// Running LCM of a stream of fractions: LCM of numerators over GCD of
// denominators, with sticky zero-rate and overflow status.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the item channel (start_req, rate_num,
// rate_den) and each one yields exactly one response on the result
// channel (base_num, base_den, status) carrying the accumulator after
// that request. start_req loads the fraction as a fresh set and clears
// the status. A zero numerator or denominator, or a numerator that no
// longer fits 64 bits, leaves the accumulator untouched and sets a
// status that holds until the next start.
// One request at a time: a folding request runs two binary GCDs of up to
// about 3*64 steps each, a 64-step divide and a 64-step multiply on one
// shared adder; start, zero-rate and held-error requests go straight from
// decode to emit. Results sit in an output register, so a new request is
// taken as soon as the sequencer is idle and the result slot is empty or
// being drained. A stalled receiver simply holds the response and keeps
// ready low on the item channel. Reset clears the accumulator to 0/0 and
// the status to ok.
// ----------------------------------------------------------------------------
module fraction_lcm_accumulator (
    input  logic          clk,
    input  logic          rst_n,
    flcm_item_if.sink     item,
    flcm_result_if.source result
);
    import flcm_pkg::*;

    seq_ctrl_t ctrl;
    alu_stat_t stat;
    val_t      x_val, y_val;
    logic      accept;

    logic      start_reg;
    val_t      num_reg, den_reg, prod_reg;
    val_t      acc_num_reg, acc_den_reg;
    status_t   err_reg, err_next;
    logic      out_valid_reg;
    val_t      out_num_reg, out_den_reg;
    status_t   out_status_reg;
    logic      zero_rate;

    assign item.ready = ctrl.idle && (!out_valid_reg || result.ready);
    assign accept     = item.valid && item.ready;
    assign zero_rate  = (num_reg == '0) || (den_reg == '0);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_reg <= item.start_req;
            num_reg   <= val_t'(item.rate_num);
            den_reg   <= val_t'(item.rate_den);
        end
        if (ctrl.save_prod)
        begin
            prod_reg <= x_val;
        end
        if (ctrl.emit)
        begin
            out_num_reg    <= acc_num_reg;
            out_den_reg    <= acc_den_reg;
            out_status_reg <= err_reg;
        end
    end

    always_comb
    begin
        err_next = err_reg;
        if (ctrl.set_zero)
        begin
            err_next = ST_ZERO;
        end
        else if (ctrl.set_ovf)
        begin
            err_next = ST_OVERFLOW;
        end
        else if (ctrl.clr_err)
        begin
            err_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_num_reg   <= '0;
            acc_den_reg   <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            err_reg <= err_next;
            if (ctrl.load_acc)
            begin
                acc_num_reg <= num_reg;
                acc_den_reg <= den_reg;
            end
            else if (ctrl.commit)
            begin
                acc_num_reg <= prod_reg;
                acc_den_reg <= y_val;
            end
            if (ctrl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    flcm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .start_req (start_reg),
        .zero_rate (zero_rate),
        .err_set   (err_reg != ST_OK),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    flcm_alu u_alu (
        .clk      (clk),
        .op       (ctrl.op),
        .acc_num  (acc_num_reg),
        .acc_den  (acc_den_reg),
        .rate_num (num_reg),
        .rate_den (den_reg),
        .x_out    (x_val),
        .y_out    (y_val),
        .stat     (stat)
    );

    assign result.valid    = out_valid_reg;
    assign result.base_num = field_t'(out_num_reg);
    assign result.base_den = field_t'(out_den_reg);
    assign result.status   = out_status_reg;

endmodule

// ----- test/flcm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flcm_checker
// Watches the request and result channels of the fraction LCM accumulator,
// keeps its own copy of the running LCM/GCD and sticky status, and compares
// every result, field by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module flcm_checker (
    input  logic   clk,
    input  logic   rst_n,
    flcm_item_if   item,
    flcm_result_if result,
    output int     fail_count,
    output int     pending
);
    import flcm_pkg::*;

    typedef struct packed {
        val_t    num;
        val_t    den;
        status_t st;
    } acc_view_t;

    val_t      lcm_num;
    val_t      gcd_den;
    status_t   sticky_st;
    acc_view_t predicted_q[$];
    int        mismatches;
    int        open_count;

    assign fail_count = mismatches;
    assign pending    = open_count;

    function automatic val_t euclid_gcd(val_t a, val_t b);
        val_t t;
        while (b != '0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    task automatic absorb_fraction(input logic start, input val_t n, input val_t d);
        val_t                       g;
        val_t                       q;
        logic [2*VALUE_WIDTH-1:0]   prod;
        if (start)
        begin
            sticky_st = ST_OK;
            if (n == '0 || d == '0)
                sticky_st = ST_ZERO;
            else
            begin
                lcm_num = n;
                gcd_den = d;
            end
        end
        else if (sticky_st == ST_OK)
        begin
            if (n == '0 || d == '0)
                sticky_st = ST_ZERO;
            else
            begin
                g    = euclid_gcd(lcm_num, n);
                q    = lcm_num / g;
                prod = (2*VALUE_WIDTH)'(q) * (2*VALUE_WIDTH)'(n);
                if (prod[2*VALUE_WIDTH-1:VALUE_WIDTH] != '0)
                    sticky_st = ST_OVERFLOW;
                else
                begin
                    lcm_num = prod[VALUE_WIDTH-1:0];
                    gcd_den = euclid_gcd(gcd_den, d);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        acc_view_t want;
        acc_view_t next_view;
        if (!rst_n)
        begin
            lcm_num    = '0;
            gcd_den    = '0;
            sticky_st  = ST_OK;
            predicted_q.delete();
            mismatches = 0;
            open_count = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (predicted_q.size() == 0)
                begin
                    $error("unexpected result: base_num %h base_den %h status %0d",
                           result.base_num, result.base_den, result.status);
                    mismatches++;
                end
                else
                begin
                    want = predicted_q.pop_front();
                    if (result.base_num !== want.num)
                    begin
                        $error("base_num: expected %h, got %h", want.num, result.base_num);
                        mismatches++;
                    end
                    if (result.base_den !== want.den)
                    begin
                        $error("base_den: expected %h, got %h", want.den, result.base_den);
                        mismatches++;
                    end
                    if (result.status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, result.status);
                        mismatches++;
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                absorb_fraction(item.start_req, val_t'(item.rate_num), val_t'(item.rate_den));
                next_view = '{lcm_num, gcd_den, sticky_st};
                predicted_q.insert(predicted_q.size(), next_view);
            end
            open_count = predicted_q.size();
        end
    end

endmodule

// ----- test/tb_fraction_lcm_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fraction_lcm_accumulator
// Drives fraction requests into the accumulator: a directed opening on the
// extremes, zero rates, overflow and sticky status, then random sets that
// start, fold and break, under three idling mixes with a long result stall.
// ----------------------------------------------------------------------------
module tb_fraction_lcm_accumulator;
    import flcm_pkg::*;

    localparam int HOLD_CYCLES     = 1500;
    localparam int TAIL_CYCLES     = 600;
    localparam int WATCHDOG_LIMIT  = 20000;

    logic        clk;
    logic        rst_n;
    logic        hold_req;
    logic        hold_done;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int          n_sent;
    int          n_recv;
    int          fail_count;
    int          pending;

    flcm_item_if   item_ch ();
    flcm_result_if res_ch ();

    fraction_lcm_accumulator uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    flcm_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_sent <= 0;
            n_recv <= 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                n_sent <= n_sent + 1;
            if (res_ch.valid && res_ch.ready)
                n_recv <= n_recv + 1;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hold off the result channel once for a long stretch
    initial
    begin
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic field_t rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic field_t pick_rate();
        int unsigned sel;
        sel = $urandom_range(0, 39);
        if (sel == 0)
            return '0;
        else if (sel <= 3)
            return rand_word();
        else if (sel <= 6)
            return field_t'(1) << $urandom_range(0, 63);
        else if (sel <= 12)
            return field_t'($urandom_range(1, 1 << 20));
        else
            return field_t'($urandom_range(1, 60));
    endfunction

    function automatic field_t pick_den(field_t base);
        int unsigned sel;
        sel = $urandom_range(0, 39);
        if (sel == 0)
            return '0;
        else if (sel <= 2)
            return rand_word();
        else
            return base * field_t'($urandom_range(1, 40));
    endfunction

    function automatic field_t noise_rate();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return field_t'(1) << $urandom_range(0, 63);
            5:       return field_t'($urandom_range(1, 60));
            default: return rand_word();
        endcase
    endfunction

    task automatic offer_request(input logic start, input field_t num, input field_t den);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.start_req <= start;
        item_ch.rate_num  <= num;
        item_ch.rate_den  <= den;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic wait_all_results();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (n_recv != n_sent);
    endtask

    task automatic stream_fraction_sets(input int count);
        int     done;
        int     len;
        field_t base;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                base = ($urandom_range(0, 9) == 0) ? rand_word()
                                                   : field_t'($urandom_range(1, 1 << 20));
                len  = $urandom_range(1, 8);
                offer_request(1'b1, pick_rate(), pick_den(base));
                for (int i = 0; i < len; i++)
                    offer_request(1'b0, pick_rate(), pick_den(base));
                done += len + 1;
            end
            else
            begin
                offer_request(1'($urandom_range(0, 1)), noise_rate(), noise_rate());
                done++;
            end
        end
    endtask

    initial
    begin
        hold_req          <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.start_req <= 1'b0;
        item_ch.rate_num  <= '0;
        item_ch.rate_den  <= '0;
        tx_idle_pct = 26;
        rx_idle_pct = 60;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // accumulate into the reset value before any start
        offer_request(1'b0, 64'd12, 64'd18);
        offer_request(1'b0, 64'd5, 64'd27);
        offer_request(1'b1, 64'd6, 64'd35);
        offer_request(1'b0, 64'd4, 64'd21);
        offer_request(1'b0, 64'd9, 64'd14);
        offer_request(1'b0, 64'd1, 64'd1);
        offer_request(1'b0, 64'd0, 64'd5);
        offer_request(1'b0, 64'd3, 64'd3);
        offer_request(1'b1, 64'd0, 64'd7);
        offer_request(1'b1, 64'd7, 64'd0);
        offer_request(1'b1, '1, '1);
        offer_request(1'b0, 64'd2, 64'd1);
        offer_request(1'b0, 64'd1, 64'd1);
        offer_request(1'b1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        offer_request(1'b0, 64'd3, 64'hC000_0000_0000_0000);
        // product lands exactly on the top of the range, then spills over
        offer_request(1'b1, 64'hFFFF_FFFF, 64'd1);
        offer_request(1'b0, 64'h1_0000_0001, 64'd1);
        offer_request(1'b0, 64'd2, 64'd1);
        offer_request(1'b1, 64'd1, 64'd1);
        offer_request(1'b0, 64'd4, 64'd8);
        offer_request(1'b0, 64'd6, 64'd9);
        offer_request(1'b0, 64'd0, 64'd0);
        offer_request(1'b1, 64'd1, '1);
        offer_request(1'b0, '1, 64'h5555_5555_5555_5555);

        stream_fraction_sets(150);
        hold_req <= 1'b1;
        stream_fraction_sets(450);
        wait_all_results();

        tx_idle_pct = 60;
        rx_idle_pct = 26;
        stream_fraction_sets(600);
        wait_all_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stream_fraction_sets(500);
        wait_all_results();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
